// File: rtl/ntpcal_pkg.sv
// Shared types, constants and table functions for the NTP seconds to calendar converter.
package ntpcal_pkg;

   // Seconds from 1 Jan 1900 to 1 Jan 2000.
   localparam logic [31:0] EPOCH_2000_SEC = 32'd3155673600;

   // Pipeline registers between the input word and the output register.
   localparam int unsigned PIPE_DEPTH = 9;

   // Seconds per day is 128 * 675; the quotient by 675 uses a reciprocal scaled by 2^34.
   localparam logic [24:0] DAY_RECIP      = 25'd25451658;
   localparam logic [9:0]  DAY_ODD_FACTOR = 10'd675;

   // Reciprocals for hours (scaled by 2^22) and minutes (scaled by 2^16).
   localparam logic [10:0] HOUR_RECIP   = 11'd1165;
   localparam logic [11:0] SEC_PER_HOUR = 12'd3600;
   localparam logic [10:0] MIN_RECIP    = 11'd1092;
   localparam logic [5:0]  SEC_PER_MIN  = 6'd60;

   // Four-year blocks start with a leap year.
   localparam logic [10:0] DAYS_PER_QUAD = 11'd1461;
   localparam logic [3:0]  MAX_QUAD      = 4'd9;

   typedef logic [13:0] days_type;   // Days since 1 Jan 2000.
   typedef logic [16:0] sod_type;    // Second of the day.
   typedef logic [8:0]  doy_type;    // Day of the year, from zero.

   // First day of a year inside a four-year block.
   function automatic logic [10:0] year_start(input logic [1:0] yin);
      logic [10:0] start;
      case (yin)
         2'd0:    start = 11'd0;
         2'd1:    start = 11'd366;
         2'd2:    start = 11'd731;
         default: start = 11'd1096;
      endcase
      return start;
   endfunction

   // First day of a month (0 = January) within its year.
   function automatic doy_type month_start(input logic leap, input logic [3:0] mon);
      doy_type start;
      case (mon)
         4'd0:    start = 9'd0;
         4'd1:    start = 9'd31;
         4'd2:    start = 9'd59;
         4'd3:    start = 9'd90;
         4'd4:    start = 9'd120;
         4'd5:    start = 9'd151;
         4'd6:    start = 9'd181;
         4'd7:    start = 9'd212;
         4'd8:    start = 9'd243;
         4'd9:    start = 9'd273;
         4'd10:   start = 9'd304;
         default: start = 9'd334;
      endcase
      // Months after February move by one day in a leap year.
      if (leap && (mon >= 4'd2)) begin
         start = start + 9'd1;
      end
      return start;
   endfunction

endpackage

// File: rtl/ntp_seconds_to_calendar.sv
// Top level: NTP seconds to calendar date and time since 2000, ten-stage pipeline.
// Throughput is one word per cycle; all stages advance together and hold while
// the response register is full and not taken, so req_tready is low only then.
// Synchronous active-high reset empties the pipeline; payload registers are not reset.
module ntp_seconds_to_calendar (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] ntp_seconds
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [5:0] year_offset, [9:6] month_number,
                                    // [14:10] day_of_month, [19:15] hour_value,
                                    // [25:20] minute_value, [31:26] second_value
   output logic        rsp_tuser    // [0] valid_res
);
   import ntpcal_pkg::*;

   logic                  advance;
   logic [PIPE_DEPTH-1:0] stage_valid_in, stage_valid_ff;
   logic [PIPE_DEPTH-1:0] stage_flag_in, stage_flag_ff;
   days_type              days;
   sod_type               sod;
   logic [5:0]            year_offset;
   logic [3:0]            month_number;
   logic [4:0]            day_of_month;
   logic [4:0]            hour_value;
   logic [5:0]            minute_value;
   logic [5:0]            second_value;
   logic                  rsp_tvalid_in, rsp_tvalid_ff;
   logic [31:0]           rsp_tdata_in, rsp_tdata_ff;
   logic                  rsp_tuser_in, rsp_tuser_ff;

   // The whole pipeline moves when the response register is empty or drained.
   assign advance    = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = advance;

   // Datapath units.
   ntpcal_day_split u_split (
      .clock       (clock),
      .advance     (advance),
      .ntp_seconds (req_tdata),
      .days        (days),
      .sod         (sod)
   );

   ntpcal_date u_date (
      .clock        (clock),
      .advance      (advance),
      .days         (days),
      .year_offset  (year_offset),
      .month_number (month_number),
      .day_of_month (day_of_month)
   );

   ntpcal_time u_time (
      .clock        (clock),
      .advance      (advance),
      .sod          (sod),
      .hour_value   (hour_value),
      .minute_value (minute_value),
      .second_value (second_value)
   );

   // Valid bits and the on-or-after-2000 flag travel with the data.
   assign stage_valid_in = {stage_valid_ff[PIPE_DEPTH-2:0], req_tvalid};
   assign stage_flag_in  = {stage_flag_ff[PIPE_DEPTH-2:0], (req_tdata >= EPOCH_2000_SEC)};

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= '0;
      end else if (advance) begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         stage_flag_ff <= stage_flag_in;
      end
   end

   // Response register; times before 2000 give an all-zero word.
   always_comb begin
      rsp_tvalid_in = stage_valid_ff[PIPE_DEPTH-1];
      rsp_tuser_in  = stage_flag_ff[PIPE_DEPTH-1];
      rsp_tdata_in  = '0;
      if (rsp_tuser_in) begin
         rsp_tdata_in = {second_value, minute_value, hour_value,
                         day_of_month, month_number, year_offset};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (advance) begin
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_tdata_ff <= rsp_tdata_in;
         rsp_tuser_ff <= rsp_tuser_in;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

   // A word flagged as before 2000 carries no date or time.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid_ff && !rsp_tuser_ff) |-> (rsp_tdata_ff == 32'd0))
      else $error("pre-2000 response word is not zero");

   // A dated word holds a month and day in range and a year no later than 2036.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid_ff && rsp_tuser_ff) |->
         ((rsp_tdata_ff[9:6] >= 4'd1) && (rsp_tdata_ff[9:6] <= 4'd12) &&
          (rsp_tdata_ff[14:10] >= 5'd1) && (rsp_tdata_ff[5:0] <= 6'd36)))
      else $error("date field out of range");

   // February never reaches day 30.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid_ff && rsp_tuser_ff && (rsp_tdata_ff[9:6] == 4'd2)) |->
         (rsp_tdata_ff[14:10] <= 5'd29))
      else $error("February day out of range");

   // Time fields stay inside their ranges after the correction steps.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid_ff && rsp_tuser_ff) |->
         ((rsp_tdata_ff[19:15] <= 5'd23) && (rsp_tdata_ff[25:20] <= 6'd59) &&
          (rsp_tdata_ff[31:26] <= 6'd59)))
      else $error("time field out of range");

   // Reset leaves no response pending.
   assert property (@(posedge clock) $past(reset) |-> !rsp_tvalid_ff)
      else $error("response valid right after reset");

endmodule

// File: rtl/ntpcal_day_split.sv
// Splits NTP seconds into a day count since 2000 and the second of the day over four stages.
module ntpcal_day_split (
   input  logic                clock,
   input  logic                advance,
   input  logic [31:0]         ntp_seconds,
   output ntpcal_pkg::days_type days,
   output ntpcal_pkg::sod_type  sod
);
   import ntpcal_pkg::*;

   logic [30:0] rem;
   logic [23:0] q1_in, q1_ff, s2_q1_ff;
   logic [6:0]  lo_in, lo_ff, s2_lo_ff, s3_lo_ff;
   logic [48:0] prod;
   days_type    qe_ff, s3_qe_ff;
   logic [23:0] back;
   logic [23:0] diff;
   logic [10:0] r0_ff;
   days_type    days_in, days_ff;
   logic [9:0]  r_fix;
   sod_type     sod_in, sod_ff;

   // Stage 1: offset to 2000; earlier times are forced to zero.
   // Seconds since 2000 stay below 2^31 over the whole input range.
   always_comb begin
      rem   = 31'(ntp_seconds - EPOCH_2000_SEC);
      q1_in = '0;
      lo_in = '0;
      if (ntp_seconds >= EPOCH_2000_SEC) begin
         q1_in = rem[30:7];
         lo_in = rem[6:0];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         q1_ff <= q1_in;
         lo_ff <= lo_in;
      end
   end

   // Stage 2: quotient estimate by 675, never high and at most one low.
   assign prod = 49'(q1_ff) * 49'(DAY_RECIP);

   always_ff @(posedge clock) begin
      if (advance) begin
         qe_ff    <= prod[47:34];
         s2_q1_ff <= q1_ff;
         s2_lo_ff <= lo_ff;
      end
   end

   // Stage 3: remainder of the estimate, below twice the divisor.
   assign back = 24'(qe_ff) * 24'(DAY_ODD_FACTOR);
   assign diff = s2_q1_ff - back;

   always_ff @(posedge clock) begin
      if (advance) begin
         r0_ff    <= diff[10:0];
         s3_qe_ff <= qe_ff;
         s3_lo_ff <= s2_lo_ff;
      end
   end

   // Stage 4: one correction step gives the day and the second of the day.
   always_comb begin
      days_in = s3_qe_ff;
      r_fix   = r0_ff[9:0];
      if (r0_ff >= 11'(DAY_ODD_FACTOR)) begin
         days_in = s3_qe_ff + 14'd1;
         r_fix   = 10'(r0_ff - 11'(DAY_ODD_FACTOR));
      end
      sod_in = {r_fix, s3_lo_ff};
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         days_ff <= days_in;
         sod_ff  <= sod_in;
      end
   end

   assign days = days_ff;
   assign sod  = sod_ff;

endmodule

// File: rtl/ntpcal_date.sv
// Turns a day count since 2000 into year offset, month and day over five stages.
module ntpcal_date (
   input  logic                 clock,
   input  logic                 advance,
   input  ntpcal_pkg::days_type days,
   output logic [5:0]           year_offset,
   output logic [3:0]           month_number,
   output logic [4:0]           day_of_month
);
   import ntpcal_pkg::*;

   logic [3:0]  quad_in, quad_ff, s6_quad_ff;
   days_type    s5_days_ff;
   logic [14:0] quad_base;
   logic [14:0] dq_full;
   logic [10:0] dq_ff;
   logic [1:0]  yin;
   logic [10:0] doy_full;
   doy_type     doy_ff, s8_doy_ff;
   logic        leap_ff, s8_leap_ff;
   logic [5:0]  year_ff, s8_year_ff, s9_year_ff;
   logic [3:0]  mon_in, mon_ff;
   doy_type     dom_full;
   logic [3:0]  month_ff;
   logic [4:0]  day_ff;

   // Stage 5: count the four-year block boundaries already passed.
   always_comb begin
      quad_in = '0;
      for (int k = 1; k <= int'(MAX_QUAD); k++) begin
         if (15'(days) >= 15'(k) * 15'(DAYS_PER_QUAD)) begin
            quad_in = quad_in + 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         quad_ff    <= quad_in;
         s5_days_ff <= days;
      end
   end

   // Stage 6: day within the four-year block.
   assign quad_base = 15'(quad_ff) * 15'(DAYS_PER_QUAD);
   assign dq_full   = 15'(s5_days_ff) - quad_base;

   always_ff @(posedge clock) begin
      if (advance) begin
         dq_ff      <= dq_full[10:0];
         s6_quad_ff <= quad_ff;
      end
   end

   // Stage 7: year inside the block and day of the year.
   always_comb begin
      yin = 2'd0;
      if (dq_ff >= year_start(2'd1)) yin = 2'd1;
      if (dq_ff >= year_start(2'd2)) yin = 2'd2;
      if (dq_ff >= year_start(2'd3)) yin = 2'd3;
      doy_full = dq_ff - year_start(yin);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         doy_ff  <= doy_full[8:0];
         leap_ff <= (yin == 2'd0);
         year_ff <= {s6_quad_ff, 2'b00} + 6'(yin);
      end
   end

   // Stage 8: month by comparing against the month starts.
   always_comb begin
      mon_in = '0;
      for (int k = 1; k < 12; k++) begin
         if (doy_ff >= month_start(leap_ff, 4'(k))) begin
            mon_in = mon_in + 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         mon_ff     <= mon_in;
         s8_doy_ff  <= doy_ff;
         s8_leap_ff <= leap_ff;
         s8_year_ff <= year_ff;
      end
   end

   // Stage 9: day of the month, both counted from one.
   assign dom_full = s8_doy_ff - month_start(s8_leap_ff, mon_ff) + 9'd1;

   always_ff @(posedge clock) begin
      if (advance) begin
         day_ff     <= dom_full[4:0];
         month_ff   <= mon_ff + 4'd1;
         s9_year_ff <= s8_year_ff;
      end
   end

   assign year_offset  = s9_year_ff;
   assign month_number = month_ff;
   assign day_of_month = day_ff;

endmodule

// File: rtl/ntpcal_time.sv
// Turns the second of the day into hour, minute and second over five stages.
module ntpcal_time (
   input  logic                clock,
   input  logic                advance,
   input  ntpcal_pkg::sod_type sod,
   output logic [4:0]          hour_value,
   output logic [5:0]          minute_value,
   output logic [5:0]          second_value
);
   import ntpcal_pkg::*;

   logic [27:0] hprod;
   logic [4:0]  he_ff, s6_he_ff;
   sod_type     s5_sod_ff;
   logic [16:0] hdiff;
   logic [12:0] hr0_ff;
   logic [4:0]  hour_in, hour_ff, s8_hour_ff, s9_hour_ff;
   logic [11:0] srem_in, srem_ff, s8_srem_ff;
   logic [22:0] mprod;
   logic [5:0]  me_ff, s9_me_ff;
   logic [11:0] sdiff;
   logic [6:0]  sr0_ff;

   // Stage 5: hour estimate, never high and at most one low.
   assign hprod = 28'(sod) * 28'(HOUR_RECIP);

   always_ff @(posedge clock) begin
      if (advance) begin
         he_ff     <= hprod[26:22];
         s5_sod_ff <= sod;
      end
   end

   // Stage 6: seconds left over after the estimated hours.
   assign hdiff = s5_sod_ff - 17'(17'(he_ff) * 17'(SEC_PER_HOUR));

   always_ff @(posedge clock) begin
      if (advance) begin
         hr0_ff   <= hdiff[12:0];
         s6_he_ff <= he_ff;
      end
   end

   // Stage 7: one correction step fixes the hour.
   always_comb begin
      hour_in = s6_he_ff;
      srem_in = hr0_ff[11:0];
      if (hr0_ff >= 13'(SEC_PER_HOUR)) begin
         hour_in = s6_he_ff + 5'd1;
         srem_in = 12'(hr0_ff - 13'(SEC_PER_HOUR));
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         hour_ff <= hour_in;
         srem_ff <= srem_in;
      end
   end

   // Stage 8: minute estimate from the second of the hour.
   assign mprod = 23'(srem_ff) * 23'(MIN_RECIP);

   always_ff @(posedge clock) begin
      if (advance) begin
         me_ff      <= mprod[21:16];
         s8_srem_ff <= srem_ff;
         s8_hour_ff <= hour_ff;
      end
   end

   // Stage 9: seconds left over after the estimated minutes.
   assign sdiff = s8_srem_ff - 12'(12'(me_ff) * 12'(SEC_PER_MIN));

   always_ff @(posedge clock) begin
      if (advance) begin
         sr0_ff     <= sdiff[6:0];
         s9_me_ff   <= me_ff;
         s9_hour_ff <= s8_hour_ff;
      end
   end

   // Final correction of minute and second, ahead of the output register.
   always_comb begin
      minute_value = s9_me_ff;
      second_value = sr0_ff[5:0];
      if (sr0_ff >= 7'(SEC_PER_MIN)) begin
         minute_value = s9_me_ff + 6'd1;
         second_value = 6'(sr0_ff - 7'(SEC_PER_MIN));
      end
   end

   assign hour_value = s9_hour_ff;

endmodule
